[sv/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int USE_W       = 32;
  localparam int STAMP_W     = 64;
  localparam int CFG_W       = 5;
  localparam int ENTRIES_DEF = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [USE_W-1:0] USE_MAX  = {USE_W{1'b1}};
  localparam logic [VAL_W-1:0] MISS_VAL = {VAL_W{1'b1}};

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [USE_W-1:0]   count;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  // controller -> datapath
  typedef struct packed {
    logic start;
    logic rd_en;
    logic commit;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic used_zero;
    logic out_free;
  } sts_t;

endpackage

[sv/lfu_ctrl.sv]
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: accepts an item, scans the held lines one per cycle, then
// commits the update and the result.
// ----------------------------------------------------------------------------
module lfu_ctrl #(
  parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [$clog2(ENTRIES+1)-1:0]      used,
  input  lfu_pkg::sts_t                     sts,
  output lfu_pkg::ctl_t                     ctl,
  output logic [(ENTRIES>1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr
);
  import lfu_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic             scan_last;

  assign in_stall  = (state_r != S_IDLE);
  assign rd_addr   = scan_r;
  assign scan_last = ((CNT_W'(scan_r) + CNT_W'(1)) == used);

  always_comb begin
    state_nxt  = state_r;
    scan_nxt   = scan_r;
    ctl.start  = 1'b0;
    ctl.rd_en  = 1'b0;
    ctl.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.start = 1'b1;
          scan_nxt  = '0;
          state_nxt = sts.used_zero ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.rd_en = 1'b1;
        if (scan_last) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_nxt = scan_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.out_free) begin
          ctl.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      scan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
    end
  end

endmodule

[sv/lfu_dp.sv]
// ----------------------------------------------------------------------------
// lfu_dp
// Line store, hit and victim tracking, fill count, clock and result register.
// ----------------------------------------------------------------------------
module lfu_dp #(
  parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [lfu_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic                              in_cmd,
  input  logic signed [lfu_pkg::KEY_W-1:0]  in_lookup_key,
  input  logic signed [lfu_pkg::VAL_W-1:0]  in_write_value,
  input  lfu_pkg::ctl_t                     ctl,
  input  logic [(ENTRIES>1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
  output lfu_pkg::sts_t                     sts,
  output logic [$clog2(ENTRIES+1)-1:0]      used,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic signed [lfu_pkg::VAL_W-1:0]  out_read_value,
  output logic                              out_evicted,
  output logic signed [lfu_pkg::KEY_W-1:0]  out_evicted_key
);
  import lfu_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  line_t mem [ENTRIES];

  logic [CFG_W-1:0]   cfg_r;
  logic [CNT_W-1:0]   used_r;
  logic [STAMP_W-1:0] clock_r;

  logic               cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [VAL_W-1:0]   val_r;

  line_t              rd_data_r;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_idx_r;

  logic               hit_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [VAL_W-1:0]   hit_val_r;
  logic [USE_W-1:0]   hit_cnt_r;

  logic               vic_have_r;
  logic [IDX_W-1:0]   vic_idx_r;
  logic [KEY_W-1:0]   vic_key_r;
  logic [USE_W-1:0]   vic_cnt_r;
  logic [STAMP_W-1:0] vic_stamp_r;

  logic               out_valid_r;
  logic               out_hit_r;
  logic [VAL_W-1:0]   out_val_r;
  logic               out_ev_r;
  logic [KEY_W-1:0]   out_evk_r;

  logic               is_put, cap_zero, full, do_write, do_insert, evict, vic_less;
  logic [IDX_W-1:0]   waddr;
  line_t              wdata;
  logic [STAMP_W-1:0] stamp_nxt;

  assign is_put    = (cmd_r == CMD_PUT);
  assign cap_zero  = (cfg_r == '0);
  // capacity above the table size counts as the table size
  assign full      = (32'(cfg_r) > 32'(ENTRIES)) ? (32'(used_r) == 32'(ENTRIES))
                                                  : (32'(used_r) >= 32'(cfg_r));
  assign do_write  = is_put ? !cap_zero : hit_r;
  assign do_insert = is_put && !cap_zero && !hit_r;
  assign evict     = do_insert && full;
  assign stamp_nxt = clock_r + STAMP_W'(1);
  assign vic_less  = (rd_data_r.count < vic_cnt_r) ||
                     ((rd_data_r.count == vic_cnt_r) && (rd_data_r.stamp < vic_stamp_r));

  always_comb begin
    wdata.key   = key_r;
    wdata.value = is_put ? val_r : hit_val_r;
    wdata.count = hit_r ? ((hit_cnt_r == USE_MAX) ? hit_cnt_r : hit_cnt_r + USE_W'(1))
                        : USE_W'(1);
    wdata.stamp = stamp_nxt;
    if (hit_r) begin
      waddr = hit_idx_r;
    end else if (full) begin
      waddr = vic_idx_r;
    end else begin
      waddr = used_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && do_write) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cmd_r <= in_cmd;
      key_r <= in_lookup_key;
      val_r <= in_write_value;
    end
    if (rd_vld_r && (rd_data_r.key == key_r)) begin
      hit_idx_r <= rd_idx_r;
      hit_val_r <= rd_data_r.value;
      hit_cnt_r <= rd_data_r.count;
    end
    if (rd_vld_r && (!vic_have_r || vic_less)) begin
      vic_idx_r   <= rd_idx_r;
      vic_key_r   <= rd_data_r.key;
      vic_cnt_r   <= rd_data_r.count;
      vic_stamp_r <= rd_data_r.stamp;
    end
    if (ctl.commit) begin
      out_hit_r <= hit_r;
      out_val_r <= is_put ? '0 : (hit_r ? hit_val_r : MISS_VAL);
      out_ev_r  <= evict;
      out_evk_r <= evict ? vic_key_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      used_r      <= '0;
      clock_r     <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      vic_have_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      rd_vld_r <= ctl.rd_en;
      if (ctl.start) begin
        hit_r      <= 1'b0;
        vic_have_r <= 1'b0;
      end else if (rd_vld_r) begin
        vic_have_r <= 1'b1;
        if (rd_data_r.key == key_r) begin
          hit_r <= 1'b1;
        end
      end
      if (ctl.commit && do_write) begin
        clock_r <= stamp_nxt;
      end
      if (ctl.commit && do_insert && !full) begin
        used_r <= used_r + CNT_W'(1);
      end
      if (ctl.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign used            = used_r;
  assign sts.used_zero   = (used_r == '0);
  assign sts.out_free    = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_val_r;
  assign out_evicted     = out_ev_r;
  assign out_evicted_key = out_evk_r;

endmodule

[sv/lfu_cache_table.sv]
// ----------------------------------------------------------------------------
// lfu_cache_table
// Key-value table with least-frequently-used replacement.
//
// Input channel (in_valid/in_stall): in_cmd 0 = get, 1 = put, with
// in_lookup_key and in_write_value. One result item per input item on the
// output channel (out_valid/out_stall): hit flag, read value (-1 on a get
// miss, 0 for puts), eviction flag and evicted key.
// cfg_wr_en/cfg_wr_data set the capacity (0 disables inserts); write only
// while idle.
// Each item scans the held lines one per cycle through the single-port line
// store (N lines held, at most ENTRIES), then passes a drain step and a
// commit step that loads the result into the output register; an empty
// table goes straight to the commit step. One item is in flight at a time;
// the next is accepted once the previous result is loaded into the output
// register.
// A stalled result holds in the output register; the block then waits in the
// commit step of the following item until the register frees up.
// Reset empties the table, zeroes the stamp clock and sets capacity to 16.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
  parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [lfu_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic signed [lfu_pkg::KEY_W-1:0]  in_lookup_key,
  input  logic signed [lfu_pkg::VAL_W-1:0]  in_write_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic signed [lfu_pkg::VAL_W-1:0]  out_read_value,
  output logic                              out_evicted,
  output logic signed [lfu_pkg::KEY_W-1:0]  out_evicted_key
);
  import lfu_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  ctl_t             ctl;
  sts_t             sts;
  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] used;

  lfu_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .used     (used),
    .sts      (sts),
    .ctl      (ctl),
    .rd_addr  (rd_addr)
  );

  lfu_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_cmd          (in_cmd),
    .in_lookup_key   (in_lookup_key),
    .in_write_value  (in_write_value),
    .ctl             (ctl),
    .rd_addr         (rd_addr),
    .sts             (sts),
    .used            (used),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );

endmodule
